/* sv/mesf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_pkg: shared definitions of the multichannel EMA sensor filter
// Word layouts, channel count, Q16 constants and configuration register codes.
// ----------------------------------------------------------------------------
package mesf_pkg;

  // Number of filtered channels and the number of them that have a mask bit.
  localparam int unsigned CHANNELS   = 11;
  localparam int unsigned MASK_BITS  = 11;
  localparam int unsigned CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths of the stream words.
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 24;

  // Configuration port.
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_ADDR_W = 2;

  // Arithmetic constants.
  localparam logic [SAMPLE_W-1:0] MID_CODE = 16'h7FFF;
  localparam logic [ALPHA_W-1:0]  Q16_ONE  = 17'd65536;

  // Reset values of the configuration registers.
  localparam logic [MASK_BITS-1:0] BIPOLAR_MASK_RST = 11'd63;
  localparam logic [ALPHA_W-1:0]   ALPHA_SENSOR_RST = 17'd45875;
  localparam logic [ALPHA_W-1:0]   ALPHA_SUPPLY_RST = 17'd58982;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BIPOLAR_MASK = 2'd0,
    REG_ALPHA_SENSOR = 2'd1,
    REG_ALPHA_SUPPLY = 2'd2
  } cfg_reg_e;

endpackage

/* sv/multichannel_ema_sensor_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_ema_sensor_filter: per-channel exponential moving average
// Converts ADC samples to signed or unsigned values and smooths each channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the slave stream carries a channel number and a raw ADC
//   conversion result. The block returns exactly one word per input word on
//   the master stream: the channel number and the channel's new filtered
//   value, new = ((1 - a) * x + a * prev) in Q16, truncated toward zero and
//   saturated to a signed 16-bit value. Bipolar channels (mask bit set) are
//   offset binary about 0x7FFF; unipolar channels pass the raw code on.
//   A channel number beyond the last channel returns a value of zero and
//   leaves every channel's state alone.
//   A word accepted into the input register moves on when the output
//   register is free or being read: its result is then loaded into the output
//   register and the channel state is written back together. One word is
//   accepted every cycle while the receiver takes words; the rate is set by
//   the single read-modify-write of the small channel register file, so words
//   for the same channel may follow each other directly.
//   When the receiver stalls, the output register holds its word and the
//   input register takes one more word before tready falls.
//   Reset clears all filter states to zero and loads the default mask and
//   alpha values. Configuration writes take effect at the next edge and
//   should only be made while the block is idle.
// ----------------------------------------------------------------------------
module multichannel_ema_sensor_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave stream. tdata: [3:0] channel, [19:4] raw_sample, [23:20] zero.
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [mesf_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // Master stream. tdata: [3:0] channel_out, [19:4] filtered_value, [23:20] zero.
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [mesf_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [mesf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [mesf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import mesf_pkg::*;

  // Configuration registers.
  logic [MASK_BITS-1:0] mask_q;
  logic [ALPHA_W-1:0]   alpha_sensor_q;
  logic [ALPHA_W-1:0]   alpha_supply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q         <= BIPOLAR_MASK_RST;
      alpha_sensor_q <= ALPHA_SENSOR_RST;
      alpha_supply_q <= ALPHA_SUPPLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_BIPOLAR_MASK: mask_q         <= cfg_wdata_i[MASK_BITS-1:0];
        REG_ALPHA_SENSOR: alpha_sensor_q <= cfg_wdata_i[ALPHA_W-1:0];
        REG_ALPHA_SUPPLY: alpha_supply_q <= cfg_wdata_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and output register with their handshake.
  logic                in_valid_q;
  logic [CHAN_W-1:0]   in_chan_q;
  logic [SAMPLE_W-1:0] in_raw_q;
  logic                out_valid_q;
  logic [CHAN_W-1:0]   out_chan_q;
  logic [VALUE_W-1:0]  out_value_q;
  logic                advance;
  logic                in_accept;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_chan_q <= s_axis_tdata_i[CHAN_W-1:0];
      in_raw_q  <= s_axis_tdata_i[CHAN_W+SAMPLE_W-1:CHAN_W];
    end
  end

  // Filter state: one signed value per channel.
  logic signed [VALUE_W-1:0] store_q [CHANNELS];

  // Update datapath. The Q16 blend is rewritten as x * 2^16 + a * (prev - x),
  // so a single multiplier does the work.
  logic                      in_range;
  logic                      bipolar;
  logic [CH_IDX_W-1:0]       idx;
  logic [ALPHA_W-1:0]        alpha_sel;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [VALUE_W-1:0] prev;
  logic signed [17:0]        x;
  logic signed [18:0]        diff;
  logic signed [36:0]        prod;
  logic signed [37:0]        num;
  logic signed [21:0]        quot;
  logic                      round_up;
  logic signed [VALUE_W-1:0] result;

  always_comb begin
    in_range = ({1'b0, in_chan_q} < (CHAN_W + 1)'(CHANNELS));
    idx      = CH_IDX_W'(in_chan_q);
    prev     = in_range ? store_q[idx] : '0;

    bipolar = 1'b0;
    if (in_range && ({1'b0, in_chan_q} < (CHAN_W + 1)'(MASK_BITS))) begin
      bipolar = mask_q[in_chan_q];
    end

    alpha_sel = bipolar ? alpha_sensor_q : alpha_supply_q;
    alpha     = (alpha_sel > Q16_ONE) ? Q16_ONE : alpha_sel;

    // Offset-binary conversion; full scale would be +32768 and is clipped.
    if (!bipolar) begin
      x = $signed({2'b00, in_raw_q});
    end else if (in_raw_q == 16'hFFFF) begin
      x = 18'sd32767;
    end else begin
      x = $signed({2'b00, in_raw_q}) - $signed({2'b00, MID_CODE});
    end

    diff = 19'(prev) - 19'(x);
    prod = $signed({1'b0, alpha}) * diff;
    num  = $signed({x, 16'h0000}) + 38'(prod);

    // Arithmetic shift floors; a negative value with a remainder moves up
    // by one to truncate toward zero.
    round_up = num[37] && (num[15:0] != 16'h0000);
    quot     = num[37:16] + {21'd0, round_up};

    if (quot > 22'sd32767) begin
      result = 16'sh7FFF;
    end else if (quot < -22'sd32768) begin
      result = -16'sh8000;
    end else begin
      result = quot[VALUE_W-1:0];
    end
    if (!in_range) begin
      result = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      store_q[idx] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_chan_q  <= in_chan_q;
      out_value_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - CHAN_W - VALUE_W)'(0), out_value_q, out_chan_q};

endmodule

/* sv/mesf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesf_checker: port-level checks of the multichannel EMA sensor filter
// Watches the stream ports of the top level and flags protocol or data slips.
// ----------------------------------------------------------------------------
module mesf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [mesf_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import mesf_pkg::*;

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // With the output register empty the block is always able to take a word.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output register is empty");

  // A channel beyond the last one reports a value of zero.
  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ({1'b0, m_axis_tdata_o[CHAN_W-1:0]} >= (CHAN_W + 1)'(CHANNELS))
    |-> m_axis_tdata_o[CHAN_W+VALUE_W-1:CHAN_W] == '0)
    else $error("non-zero value for a channel beyond the last");

  // Padding bits of the result word stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[M_TDATA_W-1:CHAN_W+VALUE_W] == '0)
    else $error("padding bits of result word are set");

endmodule

bind multichannel_ema_sensor_filter mesf_checker u_mesf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

/* test/tb_multichannel_ema_sensor_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multichannel_ema_sensor_filter: self-checking bench for the EMA filter
// Streams channel samples through the block under several mask and alpha
// settings, predicts every filtered word with an independent model of the
// per-channel state, and compares each output word field by field.
// ----------------------------------------------------------------------------
module tb_multichannel_ema_sensor_filter;
  import mesf_pkg::*;

  // Two register stages between an accepted input word and its output word.
  localparam int LATENCY = 2;

  // One expected output word: the channel echo and the new filtered value.
  typedef struct {
    logic [CHAN_W-1:0]         chan;
    logic signed [VALUE_W-1:0] value;
  } filter_word_t;

  // Scoreboard: keeps its own copy of the registers and the channel states,
  // predicts the filtered value of every accepted sample and checks the
  // output words against those predictions in order.
  class ema_scoreboard;
    logic [MASK_BITS-1:0]      mask;
    logic [ALPHA_W-1:0]        alpha_sensor;
    logic [ALPHA_W-1:0]        alpha_supply;
    logic signed [VALUE_W-1:0] level[CHANNELS];
    filter_word_t              pending_words[$];
    int                        errors;

    function new();
      mask         = BIPOLAR_MASK_RST;
      alpha_sensor = ALPHA_SENSOR_RST;
      alpha_supply = ALPHA_SUPPLY_RST;
      foreach (level[i]) level[i] = '0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_BIPOLAR_MASK: mask = value[MASK_BITS-1:0];
        REG_ALPHA_SENSOR: alpha_sensor = value[ALPHA_W-1:0];
        REG_ALPHA_SUPPLY: alpha_supply = value[ALPHA_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the new filtered value of the channel and queues it.
    function void note_sample(logic [CHAN_W-1:0] chan, logic [SAMPLE_W-1:0] raw);
      longint       weight;
      longint       sample;
      longint       blend;
      bit           bipolar;
      filter_word_t word;
      word.chan  = chan;
      word.value = '0;
      if (chan < CHANNELS) begin
        bipolar = (chan < MASK_BITS) && mask[chan];
        weight  = bipolar ? longint'(alpha_sensor) : longint'(alpha_supply);
        if (weight > longint'(Q16_ONE)) weight = longint'(Q16_ONE);
        if (bipolar) begin
          // Offset binary about mid-code; full scale would be +32768 and clips.
          sample = longint'(raw) - longint'(MID_CODE);
          if (sample > 32767) sample = 32767;
        end else begin
          sample = longint'(raw);
        end
        blend = (longint'(Q16_ONE) - weight) * sample + weight * longint'(level[chan]);
        blend = blend / longint'(Q16_ONE);  // truncates toward zero
        if (blend > 32767) blend = 32767;
        if (blend < -32768) blend = -32768;
        word.value  = blend[VALUE_W-1:0];
        level[chan] = word.value;
      end
      pending_words.push_back(word);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata);
      filter_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: output word %h arrived with nothing expected", $realtime, tdata);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (tdata[CHAN_W-1:0] !== want.chan) begin
        $display("%0t: channel_out expected %0d actual %0d", $realtime, want.chan,
                 tdata[CHAN_W-1:0]);
        errors++;
      end
      if (tdata[CHAN_W+VALUE_W-1:CHAN_W] !== want.value) begin
        $display("%0t: filtered_value (ch %0d) expected %0d actual %0d", $realtime,
                 want.chan, want.value, $signed(tdata[CHAN_W+VALUE_W-1:CHAN_W]));
        errors++;
      end
      if (tdata[M_TDATA_W-1:CHAN_W+VALUE_W] !== '0) begin
        $display("%0t: tdata padding expected 0 actual %h", $realtime,
                 tdata[M_TDATA_W-1:CHAN_W+VALUE_W]);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_valid;
  logic                    s_ready;
  logic [S_TDATA_W-1:0]    s_data;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic [M_TDATA_W-1:0]    m_data;
  logic                    cfg_we;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  ema_scoreboard board;

  // Idling percentages for the sender and the receiver, changed per phase.
  int tx_gap_pct;
  int rx_stall_pct;
  int rx_hold = 0;

  multichannel_ema_sensor_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly short pauses, now and then a long one.
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: tready is held low for random stretches. Values sampled at the
  // edge are the ones driven before it, so the check never races the block.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) board.check_result(m_data);
    if (rx_hold > 0) begin
      m_ready <= 1'b0;
      rx_hold  = rx_hold - 1;
    end else begin
      m_ready <= 1'b1;
      rx_hold  = pick_gap(rx_stall_pct);
    end
  end

  // Presents one sample word and waits for the edge that accepts it.
  task automatic send_sample(logic [CHAN_W-1:0] chan, logic [SAMPLE_W-1:0] raw);
    int gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(S_TDATA_W-CHAN_W-SAMPLE_W){1'b0}}, raw, chan};
    do @(posedge clk_i); while (!s_ready);
    board.note_sample(chan, raw);
  endtask

  // Holds the sender until every predicted word has come back, then lets the
  // pipeline settle.
  task automatic wait_drained();
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges. The write enable is
  // lowered only once, after the last write, so no step sees two updates.
  task automatic write_settings(logic [CFG_DATA_W-1:0] mask_val,
                                logic [CFG_DATA_W-1:0] sensor_val,
                                logic [CFG_DATA_W-1:0] supply_val);
    cfg_reg_e              idx[3];
    logic [CFG_DATA_W-1:0] val[3];
    idx = '{REG_BIPOLAR_MASK, REG_ALPHA_SENSOR, REG_ALPHA_SUPPLY};
    val = '{mask_val, sensor_val, supply_val};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk_i);
      board.set_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random samples: runs on one channel are common so the filter state builds
  // up, a tenth of the words go to channel numbers past the last channel, and
  // the raw codes often land on the conversion edge cases.
  task automatic send_random(int count, bit hold_midway);
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] edge_codes[6];
    edge_codes = '{16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF, 16'h8000, 16'hFFFF};
    chan = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) >= 30) begin
        if ($urandom_range(9) == 0) chan = CHAN_W'($urandom_range(CHANNELS, 15));
        else                        chan = CHAN_W'($urandom_range(0, CHANNELS - 1));
      end
      if ($urandom_range(99) < 15) raw = edge_codes[$urandom_range(0, 5)];
      else                         raw = SAMPLE_W'($urandom_range(0, 16'hFFFF));
      send_sample(chan, raw);
      // Pause the sender mid-phase until the output side has fully caught up.
      if (hold_midway && n == count / 2) begin
        s_valid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin
    logic [CHAN_W-1:0]   dir_chan[20];
    logic [SAMPLE_W-1:0] dir_raw[20];
    logic [CFG_DATA_W-1:0] phase_cfg[7][3];
    int                    phase_tx[7];
    int                    phase_rx[7];

    board        = new();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    rst_ni    <= 1'b0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_BIPOLAR_MASK;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings (channels 0 to 5 bipolar):
    // offset-binary extremes including the full-scale clip, unipolar extremes,
    // the highest channel, and channel numbers past the last channel.
    dir_chan = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd5, 4'd5, 4'd6, 4'd6,
                 4'd6, 4'd10, 4'd10, 4'd10, 4'd11, 4'd15, 4'd12, 4'd3, 4'd7, 4'd1};
    dir_raw  = '{16'h0000, 16'h7FFE, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hAAAA, 16'h5555, 16'h1234, 16'hFFFF, 16'h0000, 16'h8000,
                 16'h7FFF, 16'h0001};
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (dir_chan[i]) send_sample(dir_chan[i], dir_raw[i]);
    s_valid <= 1'b0;
    wait_drained();

    // Register settings per phase: mask, sensor alpha, supply alpha. They
    // cover an alpha of exactly one (state held), alpha above one (clamped),
    // all-bipolar and all-unipolar masks, and random mixes.
    phase_cfg[0] = '{17'h007FF, 17'd65536, 17'd0};
    phase_cfg[1] = '{17'h00000, 17'd0, 17'h1FFFF};
    phase_cfg[2] = '{CFG_DATA_W'($urandom_range(0, 2047)),
                     CFG_DATA_W'($urandom_range(0, 65536)),
                     CFG_DATA_W'($urandom_range(0, 65536))};
    phase_cfg[3] = '{17'h00555, 17'd1, 17'd65535};
    phase_cfg[4] = '{17'h002AA, 17'h1FFFF, 17'd32768};
    phase_cfg[5] = '{CFG_DATA_W'(BIPOLAR_MASK_RST), CFG_DATA_W'(ALPHA_SENSOR_RST),
                     CFG_DATA_W'(ALPHA_SUPPLY_RST)};
    phase_cfg[6] = '{CFG_DATA_W'($urandom_range(0, 2047)),
                     CFG_DATA_W'($urandom_range(0, 131071)),
                     CFG_DATA_W'($urandom_range(0, 65536))};
    phase_tx = '{10, 30, 0, 0, 50, 15, 25};
    phase_rx = '{10, 0, 30, 0, 50, 15, 25};

    for (int p = 0; p < 7; p++) begin
      write_settings(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      tx_gap_pct   = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      send_random(250, p == 2);
      s_valid <= 1'b0;
      wait_drained();
    end

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/mesf_pkg.sv
sv/multichannel_ema_sensor_filter.sv
sv/mesf_checker.sv
test/tb_multichannel_ema_sensor_filter.sv
